FILE: design/clmd_pkg.sv
`default_nettype none
package clmd_pkg;
    localparam int KEY_LEN = 14;
    localparam int KEY_POS_BITS = 5;

    localparam logic [1:0] MODE_HEADER = 2'd0;
    localparam logic [1:0] MODE_BODY = 2'd1;
    localparam logic [1:0] MODE_HALT = 2'd2;

    localparam logic [1:0] NUM_SKIP = 2'd0;
    localparam logic [1:0] NUM_DIGITS = 2'd1;
    localparam logic [1:0] NUM_DONE = 2'd2;

    localparam logic [1:0] ST_PAYLOAD = 2'd0;
    localparam logic [1:0] ST_NO_LENGTH = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_of_message;
        logic [1:0] status;
    } t_out_item;

    function automatic logic [7:0] key_char(input logic [KEY_POS_BITS-1:0] pos);
        logic [7:0] ch;
        case (pos)
            5'd0: ch = "C";
            5'd1: ch = "o";
            5'd2: ch = "n";
            5'd3: ch = "t";
            5'd4: ch = "e";
            5'd5: ch = "n";
            5'd6: ch = "t";
            5'd7: ch = "-";
            5'd8: ch = "L";
            5'd9: ch = "e";
            5'd10: ch = "n";
            5'd11: ch = "g";
            5'd12: ch = "t";
            5'd13: ch = "h";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction
endpackage
`default_nettype wire

FILE: design/clmd_if.sv
`default_nettype none
interface clmd_in_if;
    logic                valid;
    logic                ready;
    clmd_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface clmd_out_if;
    logic                valid;
    logic                ready;
    clmd_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/clmd_front.sv
`default_nettype none
module clmd_front #(
    parameter int LENGTH_BITS = 24
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire clmd_pkg::t_in_item   i_item,
    output logic                      o_ready,
    output logic                      o_push,
    output clmd_pkg::t_out_item       o_item,
    input  wire logic                 i_full
);
    import clmd_pkg::*;

    localparam logic [LENGTH_BITS-1:0] ACC_MAX = {LENGTH_BITS{1'b1}};

    logic [1:0]             r_mode, n_mode;
    logic                   r_after_le, n_after_le;
    logic                   r_nonempty, n_nonempty;
    logic [KEY_POS_BITS-1:0] r_kpos, n_kpos;
    logic                   r_kmis, n_kmis;
    logic                   r_colon, n_colon;
    logic [1:0]             r_phase, n_phase;
    logic                   r_neg, n_neg;
    logic [LENGTH_BITS-1:0] r_acc, n_acc;
    logic [LENGTH_BITS:0]   r_len, n_len;
    logic [LENGTH_BITS-1:0] r_remain, n_remain;

    logic       take;
    logic [7:0] c;
    logic       digit, blank, matched;
    logic [LENGTH_BITS+3:0] prod;
    logic [LENGTH_BITS-1:0] dec;

    assign o_ready = !i_full;
    assign take = i_valid && o_ready;
    assign c = i_item.data_byte;
    assign digit = (c >= "0") && (c <= "9");
    assign blank = (c == " ") || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
    assign matched = r_colon && !r_kmis && (r_kpos == KEY_POS_BITS'(KEY_LEN));
    assign prod = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                + {{LENGTH_BITS{1'b0}}, c[3:0]};
    assign dec = r_remain - 1'b1;

    always_comb begin
        n_mode = r_mode;
        n_after_le = r_after_le;
        n_nonempty = r_nonempty;
        n_kpos = r_kpos;
        n_kmis = r_kmis;
        n_colon = r_colon;
        n_phase = r_phase;
        n_neg = r_neg;
        n_acc = r_acc;
        n_len = r_len;
        n_remain = r_remain;
        o_push = 1'b0;
        o_item = '0;
        if (take) begin
            if (r_mode == MODE_BODY) begin
                o_push = 1'b1;
                if (i_item.end_of_input) begin
                    n_mode = MODE_HALT;
                    o_item.status = ST_TRUNCATED;
                end else begin
                    n_remain = dec;
                    o_item.payload_byte = c;
                    if (dec == '0) begin
                        o_item.last_of_message = 1'b1;
                        n_mode = MODE_HEADER;
                        n_after_le = 1'b0;
                        n_nonempty = 1'b0;
                        n_kpos = '0;
                        n_kmis = 1'b0;
                        n_colon = 1'b0;
                        n_phase = NUM_SKIP;
                        n_neg = 1'b0;
                        n_acc = '0;
                    end
                end
            end else if (r_mode == MODE_HEADER) begin
                if (i_item.end_of_input) begin
                    n_mode = MODE_HALT;
                end else if (c == CH_LF) begin
                    if (r_after_le) begin
                        if (r_len != '0 && !r_len[LENGTH_BITS]) begin
                            n_remain = r_len[LENGTH_BITS-1:0];
                            n_mode = MODE_BODY;
                        end else begin
                            o_push = 1'b1;
                            o_item.status = ST_NO_LENGTH;
                        end
                        n_len = '0;
                    end else if (r_nonempty && matched) begin
                        n_len = r_neg ? ({1'b0, r_acc} ^ {(LENGTH_BITS+1){1'b1}}) + 1'b1
                                      : {1'b0, r_acc};
                    end
                    n_nonempty = 1'b0;
                    n_kpos = '0;
                    n_kmis = 1'b0;
                    n_colon = 1'b0;
                    n_phase = NUM_SKIP;
                    n_neg = 1'b0;
                    n_acc = '0;
                    n_after_le = 1'b1;
                end else if (c != CH_CR) begin
                    n_nonempty = 1'b1;
                    n_after_le = 1'b0;
                    if (!r_colon) begin
                        if (c == CH_COLON) begin
                            n_colon = 1'b1;
                        end else if (r_kpos < KEY_POS_BITS'(KEY_LEN) && c == key_char(r_kpos)) begin
                            n_kpos = r_kpos + 1'b1;
                        end else begin
                            n_kmis = 1'b1;
                        end
                    end else if (matched) begin
                        if (r_phase == NUM_SKIP) begin
                            if (blank) begin
                                n_phase = NUM_SKIP;
                            end else if (c == "+" || c == "-") begin
                                n_neg = (c == "-");
                                n_phase = NUM_DIGITS;
                            end else if (!digit) begin
                                n_phase = NUM_DONE;
                            end else begin
                                n_phase = NUM_DIGITS;
                                n_acc = (prod > {4'b0, ACC_MAX}) ? ACC_MAX : prod[LENGTH_BITS-1:0];
                            end
                        end else if (r_phase == NUM_DIGITS) begin
                            if (digit) begin
                                n_acc = (prod > {4'b0, ACC_MAX}) ? ACC_MAX : prod[LENGTH_BITS-1:0];
                            end else begin
                                n_phase = NUM_DONE;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HEADER;
            r_after_le <= 1'b0;
            r_nonempty <= 1'b0;
            r_kpos <= '0;
            r_kmis <= 1'b0;
            r_colon <= 1'b0;
            r_phase <= NUM_SKIP;
            r_neg <= 1'b0;
            r_acc <= '0;
            r_len <= '0;
            r_remain <= '0;
        end else begin
            r_mode <= n_mode;
            r_after_le <= n_after_le;
            r_nonempty <= n_nonempty;
            r_kpos <= n_kpos;
            r_kmis <= n_kmis;
            r_colon <= n_colon;
            r_phase <= n_phase;
            r_neg <= n_neg;
            r_acc <= n_acc;
            r_len <= n_len;
            r_remain <= n_remain;
        end
    end

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_HALT |=> r_mode == MODE_HALT) else $error("halt left");
    a_body_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_BODY |-> r_remain != '0) else $error("empty body");
    a_kpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kpos <= KEY_POS_BITS'(KEY_LEN)) else $error("key position");
endmodule
`default_nettype wire

FILE: design/clmd_queue.sv
`default_nettype none
module clmd_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire clmd_pkg::t_out_item  i_item,
    output logic                      o_full,
    clmd_out_if.source                out_ch
);
    import clmd_pkg::*;

    t_out_item  r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_full = (r_count == 2'd2);
    assign out_ch.valid = (r_count != 2'd0);
    assign out_ch.data = r_mem[r_rptr];
    assign pop = out_ch.valid && out_ch.ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overflow");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("queue count");
    a_ptr_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> r_wptr == r_rptr) else $error("queue pointers");
endmodule
`default_nettype wire

FILE: design/content_length_message_deframer_core.sv
// Content-Length message deframer.
// The in_ch channel carries one stream byte per item, or an end-of-input mark.
// The out_ch channel carries body bytes with a last flag, a status for a
// blank line that had no usable length, and a status for a truncated body.
// The header parser takes one item per cycle while the queue has room and decides
// in that cycle what, if anything, it produces. Results wait in a two-entry queue.
// A result is held in the queue from the cycle after the item that caused it.
// Throughput is one item per cycle while the queue has room.
// When the receiver stalls, the queue fills and in_ch.ready drops, so no
// result is lost; items that produce no result also wait for room.
// Reset puts the parser in header mode with no recorded length and empties
// the queue. After end of input the block ignores items until reset.
`default_nettype none
module content_length_message_deframer_core #(
    parameter int LENGTH_BITS = 24
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    clmd_in_if.sink    in_ch,
    clmd_out_if.source out_ch
);
    import clmd_pkg::*;

    logic      push, full;
    t_out_item item;

    clmd_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_ch.valid), .i_item(in_ch.data), .o_ready(in_ch.ready),
        .o_push(push), .o_item(item), .i_full(full)
    );

    clmd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_item(item), .o_full(full), .out_ch(out_ch)
    );
endmodule
`default_nettype wire

FILE: test/content_length_message_deframer_core_tb.sv
`default_nettype none
class frame_scoreboard;
    clmd_pkg::t_out_item pending[$];
    int errors;
    logic [1:0] mode;
    bit after_lf, nonempty, mismatch, colon, negative;
    int unsigned keypos;
    logic [1:0] nphase;
    longint unsigned acc, msg_len, remaining;

    function new();
        errors = 0;
        mode = clmd_pkg::MODE_HEADER;
        after_lf = 0;
        msg_len = 0;
        remaining = 0;
        clear_line();
    endfunction

    function void clear_line();
        nonempty = 0;
        keypos = 0;
        mismatch = 0;
        colon = 0;
        nphase = clmd_pkg::NUM_SKIP;
        negative = 0;
        acc = 0;
    endfunction

    function bit key_ok();
        return colon && !mismatch && keypos == clmd_pkg::KEY_LEN;
    endfunction

    function void push(logic [7:0] b, logic [1:0] st, bit last);
        clmd_pkg::t_out_item r;
        r.payload_byte = b;
        r.last_of_message = last;
        r.status = st;
        pending.insert(pending.size(), r);
    endfunction

    function void feed_digit(logic [7:0] c);
        bit digit;
        longint unsigned v;
        digit = (c >= "0" && c <= "9");
        if (nphase == clmd_pkg::NUM_SKIP) begin
            if (c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C) return;
            if (c == "+" || c == "-") begin
                negative = (c == "-");
                nphase = clmd_pkg::NUM_DIGITS;
                return;
            end
            if (!digit) begin
                nphase = clmd_pkg::NUM_DONE;
                return;
            end
            nphase = clmd_pkg::NUM_DIGITS;
        end
        if (nphase == clmd_pkg::NUM_DIGITS) begin
            if (digit) begin
                v = acc * 10 + (c - "0");
                acc = (v > 64'hFFFFFF) ? 64'hFFFFFF : v;
            end else begin
                nphase = clmd_pkg::NUM_DONE;
            end
        end
    endfunction

    function void note_input(clmd_pkg::t_in_item it);
        logic [7:0] c;
        c = it.data_byte;
        if (mode == clmd_pkg::MODE_BODY) begin
            if (it.end_of_input) begin
                mode = clmd_pkg::MODE_HALT;
                push(8'd0, clmd_pkg::ST_TRUNCATED, 0);
                return;
            end
            remaining = (remaining - 1) & 64'hFFFFFF;
            push(c, clmd_pkg::ST_PAYLOAD, remaining == 0);
            if (remaining == 0) begin
                mode = clmd_pkg::MODE_HEADER;
                after_lf = 0;
                clear_line();
            end
            return;
        end
        if (mode != clmd_pkg::MODE_HEADER) return;
        if (it.end_of_input) begin
            mode = clmd_pkg::MODE_HALT;
            return;
        end
        if (c == clmd_pkg::CH_LF) begin
            if (after_lf) begin
                if (msg_len != 0 && msg_len[24] == 0) begin
                    remaining = msg_len & 64'hFFFFFF;
                    mode = clmd_pkg::MODE_BODY;
                end else begin
                    push(8'd0, clmd_pkg::ST_NO_LENGTH, 0);
                end
                msg_len = 0;
            end else if (nonempty && key_ok()) begin
                msg_len = (negative ? (64'd0 - acc) : acc) & 64'h1FFFFFF;
            end
            clear_line();
            after_lf = 1;
            return;
        end
        if (c == clmd_pkg::CH_CR) return;
        nonempty = 1;
        after_lf = 0;
        if (!colon) begin
            if (c == clmd_pkg::CH_COLON) colon = 1;
            else if (keypos < clmd_pkg::KEY_LEN && c == clmd_pkg::key_char(keypos[4:0]))
                keypos++;
            else mismatch = 1;
        end else if (key_ok()) begin
            feed_digit(c);
        end
    endfunction

    function void check_result(clmd_pkg::t_out_item got);
        clmd_pkg::t_out_item exp_r;
        if (pending.size() == 0) begin
            $error("unexpected result %h", got);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (got.status !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, got.status);
            errors++;
        end
        if (got.payload_byte !== exp_r.payload_byte) begin
            $error("payload_byte expected %h actual %h", exp_r.payload_byte,
                   got.payload_byte);
            errors++;
        end
        if (got.last_of_message !== exp_r.last_of_message) begin
            $error("last_of_message expected %b actual %b", exp_r.last_of_message,
                   got.last_of_message);
            errors++;
        end
    endfunction
endclass

module content_length_message_deframer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import clmd_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    clmd_in_if in_ch();
    clmd_out_if out_ch();
    frame_scoreboard sb;
    int send_idle_pct = 21;
    int recv_idle_pct = 82;
    bit hold_off = 0;
    byte unsigned stream[$];

    content_length_message_deframer_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch));

    always #2 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 0;
        in_ch.data = '0;
        out_ch.ready = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
        out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_item(logic [7:0] b, bit eoi);
        t_in_item it;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        it.data_byte = b;
        it.end_of_input = eoi;
        in_ch.valid <= 1;
        in_ch.data <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_input(it);
    endtask

    task automatic flush_stream();
        while (stream.size() > 0) send_item(stream.pop_front(), 0);
    endtask

    task automatic add_byte(logic [7:0] b);
        stream.insert(stream.size(), b);
    endtask

    task automatic add_text(string s);
        foreach (s[k]) add_byte(s[k]);
    endtask

    task automatic add_message(int len, bit cr);
        string v;
        v.itoa(len);
        add_text("Content-Length: ");
        add_text(v);
        if (cr) add_byte(8'h0D);
        add_byte(8'h0A);
        if (cr) add_byte(8'h0D);
        add_byte(8'h0A);
        repeat (len) add_byte(8'($urandom_range(255)));
    endtask

    task automatic idle_drain();
        in_ch.valid <= 0;
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        int sent;
        int r;
        string s;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(99);
            if (r < 65) add_message($urandom_range(12), $urandom_range(1));
            else if (r < 75) begin
                s.itoa($urandom_range(40));
                if ($urandom_range(1)) add_text("Content-Length:\t+");
                else add_text("X-Other: ");
                add_text(s);
                add_text("\n\n");
            end else if (r < 85) begin
                add_text("Content-Lengt: 3\nContent-Length:-5\n\n");
            end else begin
                repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(255)));
            end
            sent += stream.size();
            flush_stream();
        end
    endtask

    task automatic do_reset();
        i_rst_n <= 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        do_reset();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_message(1, 1);
        add_text("Content-Length:  99999999999\nContent-Length: 2\n\nab");
        add_text("content-length: 3\n\n");
        add_text("Content-Length: -0\n\nContent-Length: x\n\n");
        add_text("Content-Length:\v\f7junk\r\n\r\n");
        add_byte(8'hFF);
        repeat (6) add_byte(8'h00);
        add_text("Content-LengthX: 4\n\n");
        flush_stream();
        idle_drain();
        send_idle_pct = 21;
        recv_idle_pct = 82;
        random_phase(560);
        idle_drain();
        hold_off = 1;
        fork
            begin
                add_message(20, 0);
                flush_stream();
            end
            begin
                repeat (200) @(posedge i_clk);
                hold_off = 0;
            end
        join
        send_idle_pct = 82;
        recv_idle_pct = 21;
        random_phase(560);
        idle_drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(560);
        add_message(30, 1);
        stream = stream[0:stream.size() - 10];
        flush_stream();
        send_item(8'h41, 1);
        send_item(8'h42, 0);
        send_item(8'h0A, 1);
        idle_drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("content_length_message_deframer_core test passed");
        else
            $display("content_length_message_deframer_core test failed");
        $finish;
    end

    initial begin
        #4ms;
        $display("content_length_message_deframer_core test failed");
        $finish;
    end
endmodule
`default_nettype wire
